// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // field widths
   localparam int FUNC_W = 3;
   localparam int CHAR_W = 8;
   localparam int GCOL_W = 7;
   localparam int GROW_W = 5;
   localparam int RIDX_W = 11;
   localparam int POS_W  = 11;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TEXT_COLOR  = 1'b0;
   localparam logic REG_BLANK_COLOR = 1'b1;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GOTO   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SCROLL = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;

   // attribute of every cell after reset, and reset value of both colors
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

   // cursor update codes
   localparam logic [2:0] CUR_HOLD    = 3'd0;
   localparam logic [2:0] CUR_ADVANCE = 3'd1;
   localparam logic [2:0] CUR_NEWLINE = 3'd2;
   localparam logic [2:0] CUR_BACK    = 3'd3;
   localparam logic [2:0] CUR_GOTO    = 3'd4;
   localparam logic [2:0] CUR_HOME    = 3'd5;
   localparam logic [2:0] CUR_UP_SAT  = 3'd6;

   // cell store write codes
   localparam logic [2:0] MEM_NONE       = 3'd0;
   localparam logic [2:0] MEM_CUR_CHAR   = 3'd1;
   localparam logic [2:0] MEM_CUR_BLANK  = 3'd2;
   localparam logic [2:0] MEM_MOVE       = 3'd3;
   localparam logic [2:0] MEM_FILL_BLANK = 3'd4;
   localparam logic [2:0] MEM_FILL_INIT  = 3'd5;

   // walk counter codes
   localparam logic [1:0] WALK_HOLD   = 2'd0;
   localparam logic [1:0] WALK_ZERO   = 2'd1;
   localparam logic [1:0] WALK_BOTTOM = 2'd2;
   localparam logic [1:0] WALK_INC    = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [GCOL_W-1:0] goto_col;
      logic [GROW_W-1:0] goto_row;
      logic              scroll_dir;
      logic [RIDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attr;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic [2:0] cur_op;
      logic [2:0] mem_op;
      logic [1:0] walk_op;
      logic       move_rd;
      logic       move_up;
      logic       rd_cell;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              is_newline;
      logic              is_backspace;
      logic              at_origin;
      logic              col_last;
      logic              row_last;
      logic              scroll_up;
      logic              move_end;
      logic              fill_end;
      logic              fill_top_end;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/tcw_csr.sv
// ----------------------------------------------------------------------------
// tcw_csr
// APB-style register file holding the text and blank attribute bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [tcw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [tcw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   output logic      [tcw_pkg::ATTR_W-1:0]      text_color,
   output logic      [tcw_pkg::ATTR_W-1:0]      blank_color
);

   import tcw_pkg::*;

   logic              reg_sel;
   logic              wr_go;
   logic [ATTR_W-1:0] text_color_ff, text_color_in;
   logic [ATTR_W-1:0] blank_color_ff, blank_color_in;
   logic [ATTR_W-1:0] rd_value;

   // registers sit on 4-byte strides
   assign reg_sel = paddr[2];
   assign pready  = 1'b1;
   assign wr_go   = psel && penable && pwrite && pready;

   always_comb begin
      text_color_in  = text_color_ff;
      blank_color_in = blank_color_ff;
      rd_value       = text_color_ff;
      unique case (reg_sel)
         REG_TEXT_COLOR: begin
            rd_value = text_color_ff;
            if (wr_go) text_color_in = pwdata[ATTR_W-1:0];
         end
         REG_BLANK_COLOR: begin
            rd_value = blank_color_ff;
            if (wr_go) blank_color_in = pwdata[ATTR_W-1:0];
         end
         default: rd_value = text_color_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff  <= RESET_ATTR;
         blank_color_ff <= RESET_ATTR;
      end else begin
         text_color_ff  <= text_color_in;
         blank_color_ff <= blank_color_in;
      end
   end

   assign prdata      = CSR_DATA_W'(rd_value);
   assign text_color  = text_color_ff;
   assign blank_color = blank_color_ff;

endmodule

`default_nettype wire

// File: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor registers, cell store, address walker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tcw_pkg::req_type           req_data,
   output tcw_pkg::rsp_type                rsp_data,
   input  wire logic [tcw_pkg::ATTR_W-1:0] text_color,
   input  wire logic [tcw_pkg::ATTR_W-1:0] blank_color,
   input  wire tcw_pkg::cmd_type           cmd,
   output tcw_pkg::status_type             status
);

   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);

   req_type           req_ff;
   logic              rd_hit_ff, rd_hit_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              wr_pend_ff;
   logic [ADDR_W-1:0] dst_ff;
   rsp_type           rsp_ff;

   logic [ADDR_W-1:0] here;
   logic [ADDR_W-1:0] mv_dst, mv_src;
   logic              col_last, row_last;
   logic              we;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;
   logic [CELL_W-1:0] blank_cell;

   assign here       = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign col_last   = (col_ff == COL_W'(COLUMNS - 1));
   assign row_last   = (row_ff == ROW_W'(ROWS - 1));
   assign blank_cell = {blank_color, CH_BLANK};
   assign rd_hit_in  = (req_data.func == FUNC_READ) && (32'(req_data.read_index) < CELLS);

   // copy addresses: up copies row below into this one, down walks from the end
   assign mv_dst = cmd.move_up ? cnt_ff : ADDR_W'(CELLS - 1) - cnt_ff;
   assign mv_src = cmd.move_up ? cnt_ff + ADDR_W'(COLUMNS)
                               : ADDR_W'(CELLS - 1 - COLUMNS) - cnt_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      unique case (cmd.cur_op)
         CUR_HOLD: ;
         CUR_ADVANCE: begin
            if (col_last) begin
               col_in = '0;
               if (!row_last) row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         CUR_NEWLINE: begin
            col_in = '0;
            if (!row_last) row_in = row_ff + 1'b1;
         end
         CUR_BACK: begin
            if (col_ff == '0) begin
               col_in = COL_W'(COLUMNS - 1);
               row_in = row_ff - 1'b1;
            end else begin
               col_in = col_ff - 1'b1;
            end
         end
         CUR_GOTO: begin
            if (32'(req_ff.goto_col) > COLUMNS - 1) col_in = COL_W'(COLUMNS - 1);
            else                                    col_in = COL_W'(req_ff.goto_col);
            if (32'(req_ff.goto_row) > ROWS - 1) row_in = ROW_W'(ROWS - 1);
            else                                 row_in = ROW_W'(req_ff.goto_row);
         end
         CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         CUR_UP_SAT: begin
            if (row_ff != '0) row_in = row_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      unique case (cmd.walk_op)
         WALK_HOLD:   cnt_in = cnt_ff;
         WALK_ZERO:   cnt_in = '0;
         WALK_BOTTOM: cnt_in = ADDR_W'(CELLS - COLUMNS);
         WALK_INC:    cnt_in = cnt_ff + 1'b1;
         default:     cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      we      = 1'b0;
      wr_addr = here;
      wr_data = blank_cell;
      unique case (cmd.mem_op)
         MEM_NONE: ;
         MEM_CUR_CHAR: begin
            we      = 1'b1;
            wr_data = {text_color, req_ff.char_code};
         end
         MEM_CUR_BLANK: we = 1'b1;
         MEM_MOVE: begin
            we      = wr_pend_ff;
            wr_addr = dst_ff;
            wr_data = rd_data;
         end
         MEM_FILL_BLANK: begin
            we      = 1'b1;
            wr_addr = cnt_ff;
         end
         MEM_FILL_INIT: begin
            we      = 1'b1;
            wr_addr = cnt_ff;
            wr_data = {RESET_ATTR, CH_BLANK};
         end
         default: ;
      endcase
   end

   assign rd_en   = cmd.move_rd || (cmd.rd_cell && rd_hit_ff);
   assign rd_addr = cmd.move_rd ? mv_src : ADDR_W'(req_ff.read_index);

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         cnt_ff     <= '0;
         wr_pend_ff <= 1'b0;
         rd_hit_ff  <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         cnt_ff     <= cnt_in;
         wr_pend_ff <= cmd.move_rd;
         if (cmd.load) rd_hit_ff <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.move_rd) dst_ff <= mv_dst;
      if (cmd.out_load) begin
         rsp_ff.cursor_pos <= POS_W'(here);
         rsp_ff.read_char  <= rd_hit_ff ? rd_data[CHAR_W-1:0] : '0;
         rsp_ff.read_attr  <= rd_hit_ff ? rd_data[CELL_W-1:CHAR_W] : '0;
      end
   end

   assign rsp_data = rsp_ff;

   assign status.func         = req_ff.func;
   assign status.is_newline   = (req_ff.char_code == CH_NEWLINE);
   assign status.is_backspace = (req_ff.char_code == CH_BACKSPACE);
   assign status.at_origin    = (col_ff == '0) && (row_ff == '0);
   assign status.col_last     = col_last;
   assign status.row_last     = row_last;
   assign status.scroll_up    = req_ff.scroll_dir;
   assign status.move_end     = (cnt_ff == ADDR_W'(CELLS - COLUMNS - 1));
   assign status.fill_end     = (cnt_ff == ADDR_W'(CELLS - 1));
   assign status.fill_top_end = (cnt_ff == ADDR_W'(COLUMNS - 1));

endmodule

`default_nettype wire

// File: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: decodes a transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire tcw_pkg::status_type  status,
   output tcw_pkg::cmd_type          cmd
);

   import tcw_pkg::*;

   localparam logic [3:0] S_INIT      = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DECODE    = 4'd2;
   localparam logic [3:0] S_BS_WRITE  = 4'd3;
   localparam logic [3:0] S_MOVE      = 4'd4;
   localparam logic [3:0] S_MOVE_LAST = 4'd5;
   localparam logic [3:0] S_FILL      = 4'd6;
   localparam logic [3:0] S_FILL_TOP  = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       up_ff, up_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      up_in    = up_ff;
      cmd      = '0;
      cmd.cur_op  = CUR_HOLD;
      cmd.mem_op  = MEM_NONE;
      cmd.walk_op = WALK_HOLD;
      cmd.move_up = up_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.mem_op  = MEM_FILL_INIT;
            cmd.walk_op = WALK_INC;
            if (status.fill_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in    = S_DONE;
            cmd.walk_op = WALK_ZERO;
            unique case (status.func)
               FUNC_PUT: begin
                  if (status.is_newline) begin
                     cmd.mem_op = MEM_CUR_BLANK;
                     cmd.cur_op = CUR_NEWLINE;
                     up_in      = 1'b1;
                     if (status.row_last) state_in = S_MOVE;
                  end else if (status.is_backspace) begin
                     if (!status.at_origin) begin
                        cmd.cur_op = CUR_BACK;
                        state_in   = S_BS_WRITE;
                     end
                  end else begin
                     cmd.mem_op = MEM_CUR_CHAR;
                     cmd.cur_op = CUR_ADVANCE;
                     up_in      = 1'b1;
                     if (status.col_last && status.row_last) state_in = S_MOVE;
                  end
               end
               FUNC_GOTO:  cmd.cur_op = CUR_GOTO;
               FUNC_CLEAR: begin
                  cmd.cur_op = CUR_HOME;
                  state_in   = S_FILL;
               end
               FUNC_SCROLL: begin
                  up_in    = status.scroll_up;
                  state_in = S_MOVE;
                  if (status.scroll_up) cmd.cur_op = CUR_UP_SAT;
               end
               FUNC_READ:  cmd.rd_cell = 1'b1;
               default: ;
            endcase
         end
         S_BS_WRITE: begin
            cmd.mem_op = MEM_CUR_BLANK;
            state_in   = S_DONE;
         end
         S_MOVE: begin
            cmd.move_rd = 1'b1;
            cmd.mem_op  = MEM_MOVE;
            cmd.walk_op = WALK_INC;
            if (status.move_end) state_in = S_MOVE_LAST;
         end
         S_MOVE_LAST: begin
            cmd.mem_op = MEM_MOVE;
            if (up_ff) begin
               cmd.walk_op = WALK_BOTTOM;
               state_in    = S_FILL;
            end else begin
               cmd.walk_op = WALK_ZERO;
               state_in    = S_FILL_TOP;
            end
         end
         S_FILL: begin
            cmd.mem_op  = MEM_FILL_BLANK;
            cmd.walk_op = WALK_INC;
            if (status.fill_end) state_in = S_DONE;
         end
         S_FILL_TOP: begin
            cmd.mem_op  = MEM_FILL_BLANK;
            cmd.walk_op = WALK_INC;
            if (status.fill_top_end) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)   rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         up_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         up_ff        <= up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen engine: character/attribute grid with cursor, wrap,
// newline, backspace, auto scroll, goto, clear, explicit scroll and reads.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | tcw_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall  | tcw_pkg::rsp_type
//   csr     | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
// Clear, scroll, and a character or newline off the last row walk the grid;
//   the passes move one cell per cycle through one RAM port.
// Reset: a pass rewrites every cell; req_stall stays high until it ends (csr
//   writes work). Stalls: a request is taken while a result waits in the
//   result register; its own result then waits until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire tcw_pkg::req_type                req_data,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output tcw_pkg::rsp_type                     rsp_data,
   // configuration
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [tcw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [tcw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   import tcw_pkg::*;

   // attribute bytes from the register file
   logic [ATTR_W-1:0] text_color;
   logic [ATTR_W-1:0] blank_color;

   // sequencer <-> datapath
   cmd_type    cmd;
   status_type status;

   tcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .text_color  (text_color),
      .blank_color (blank_color)
   );

   // sequencer: owns the handshakes and the step order of each transaction
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: cursor, cell RAM, copy/fill walker, result register
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .text_color  (text_color),
      .blank_color (blank_color),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

// File: dv/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A queue-fed driver pushes
// console commands (put char, goto, clear, scroll, cell read, unknown codes)
// through the req channel with random gaps. A monitor takes every rsp
// transaction under random stall and checks it field by field against a
// cycle-free model of the screen grid, cursor and color registers. Colors
// are reprogrammed over the csr port between phases, only while the block
// is drained.
// ----------------------------------------------------------------------------

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

   // every input is known from time zero
   logic                   clock   = 1'b0;
   logic                   reset   = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   psel    = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr   = '0;
   logic [CSR_DATA_W-1:0]  pwdata  = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   text_console_writer #(
      .COLUMNS (SCREEN_COLS),
      .ROWS    (SCREEN_ROWS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Screen model: its own copy of the grid, the cursor and both colors.
   // Each cell keeps the attribute in the high byte, the character below.
   // -------------------------------------------------------------------------
   logic [CELL_W-1:0] screen_cells [SCREEN_CELLS];
   int                cursor_col;
   int                cursor_row;
   logic [ATTR_W-1:0] text_attr  = RESET_ATTR;
   logic [ATTR_W-1:0] blank_attr = RESET_ATTR;

   req_type pending_cmds[$];    // commands not yet presented on req
   rsp_type predicted_rsps[$];  // results owed by accepted commands
   int      mismatch_count = 0;

   // Quiet modes: a long stretch where neither side idles.
   logic feed_calm = 1'b0;
   logic sink_calm = 1'b0;

   initial begin
      for (int i = 0; i < SCREEN_CELLS; i++)
         screen_cells[i] = {RESET_ATTR, CH_BLANK};
      cursor_col = 0;
      cursor_row = 0;
   end

   // every row moves up one, bottom row blanked
   function automatic void scroll_screen_up();
      for (int i = 0; i + SCREEN_COLS < SCREEN_CELLS; i++)
         screen_cells[i] = screen_cells[i + SCREEN_COLS];
      for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
         screen_cells[i] = {blank_attr, CH_BLANK};
   endfunction

   // Applies one console command to the model and returns the result
   // the block owes for it.
   function automatic rsp_type apply_console_cmd(req_type cmd);
      rsp_type           res;
      int                here;
      logic [CELL_W-1:0] blank;
      res   = '0;
      here  = cursor_row * SCREEN_COLS + cursor_col;
      blank = {blank_attr, CH_BLANK};
      case (cmd.func)
         FUNC_PUT: begin
            if (cmd.char_code == CH_NEWLINE) begin
               screen_cells[here] = blank;
               cursor_col = 0;
               cursor_row++;
            end else if (cmd.char_code == CH_BACKSPACE) begin
               // nothing happens at the origin
               if (cursor_col != 0 || cursor_row != 0) begin
                  if (cursor_col == 0) begin
                     cursor_col = SCREEN_COLS - 1;
                     cursor_row--;
                  end else begin
                     cursor_col--;
                  end
                  screen_cells[cursor_row * SCREEN_COLS + cursor_col] = blank;
               end
            end else begin
               screen_cells[here] = {text_attr, cmd.char_code};
               cursor_col++;
               if (cursor_col > SCREEN_COLS - 1) begin
                  cursor_col = 0;
                  cursor_row++;
               end
            end
            // running off the last row scrolls the screen
            while (cursor_row > SCREEN_ROWS - 1) begin
               scroll_screen_up();
               cursor_row--;
            end
         end
         FUNC_GOTO: begin
            cursor_col = (cmd.goto_col > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : cmd.goto_col;
            cursor_row = (cmd.goto_row > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : cmd.goto_row;
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < SCREEN_CELLS; i++)
               screen_cells[i] = blank;
            cursor_col = 0;
            cursor_row = 0;
         end
         FUNC_SCROLL: begin
            if (cmd.scroll_dir) begin
               scroll_screen_up();
               if (cursor_row > 0)
                  cursor_row--;
            end else begin
               for (int i = SCREEN_CELLS - 1; i >= SCREEN_COLS; i--)
                  screen_cells[i] = screen_cells[i - SCREEN_COLS];
               for (int i = 0; i < SCREEN_COLS; i++)
                  screen_cells[i] = blank;
            end
         end
         FUNC_READ: begin
            // indexes past the grid read as zero
            if (cmd.read_index < SCREEN_CELLS) begin
               res.read_char = screen_cells[cmd.read_index][CHAR_W-1:0];
               res.read_attr = screen_cells[cmd.read_index][CELL_W-1:CHAR_W];
            end
         end
         default: ;  // unknown codes change nothing
      endcase
      res.cursor_pos = POS_W'(cursor_row * SCREEN_COLS + cursor_col);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Driver: presents the next pending command whenever the previous one was
   // taken (or nothing was offered). The model is advanced at acceptance.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predicted_rsps.push_back(apply_console_cmd(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 && (feed_calm || $urandom_range(0, 99) >= 8)) begin
               req_data  <= pending_cmds.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks each rsp transaction against the oldest prediction and
   // stalls at random.
   // -------------------------------------------------------------------------
   task automatic check_console_rsp(input rsp_type got);
      rsp_type want;
      if (predicted_rsps.size() == 0) begin
         $error("unexpected transaction: cursor_pos %0d read_char %0d read_attr %0d",
                got.cursor_pos, got.read_char, got.read_attr);
         mismatch_count++;
      end else begin
         want = predicted_rsps.pop_front();
         if (got.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, got.cursor_pos);
            mismatch_count++;
         end
         if (got.read_char !== want.read_char) begin
            $error("read_char: expected %0d, actual %0d", want.read_char, got.read_char);
            mismatch_count++;
         end
         if (got.read_attr !== want.read_attr) begin
            $error("read_attr: expected %0d, actual %0d", want.read_attr, got.read_attr);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_console_rsp(rsp_data);
         rsp_stall <= !sink_calm && ($urandom_range(0, 99) < 8);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic req_type make_req(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                                        logic [GCOL_W-1:0] col, logic [GROW_W-1:0] row,
                                        logic dir, logic [RIDX_W-1:0] idx);
      req_type cmd;
      cmd.func       = func;
      cmd.char_code  = ch;
      cmd.goto_col   = col;
      cmd.goto_row   = row;
      cmd.scroll_dir = dir;
      cmd.read_index = idx;
      return cmd;
   endfunction

   // unused fields carry random junk so every bit toggles
   function automatic req_type random_req(logic [FUNC_W-1:0] func);
      return make_req(func, CHAR_W'($urandom_range(0, 255)), GCOL_W'($urandom_range(0, 127)),
                      GROW_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                      RIDX_W'($urandom_range(0, 2047)));
   endfunction

   // Mostly runs of text, with line control, cursor moves and reads mixed
   // in; screen-wide passes (clear, scroll) kept rare since each one walks
   // every cell.
   task automatic queue_random_cmds(input int count);
      req_type cmd;
      int      roll;
      int      made;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            repeat ($urandom_range(1, 8)) begin
               cmd = random_req(FUNC_PUT);
               if ($urandom_range(0, 4) != 0)
                  cmd.char_code = CHAR_W'($urandom_range(32, 126));
               if (cmd.char_code == CH_NEWLINE || cmd.char_code == CH_BACKSPACE)
                  cmd.char_code = "*";
               pending_cmds.push_back(cmd);
               made++;
            end
         end else begin
            if (roll < 50) begin
               cmd = random_req(FUNC_PUT);
               cmd.char_code = CH_NEWLINE;
            end else if (roll < 56) begin
               cmd = random_req(FUNC_PUT);
               cmd.char_code = CH_BACKSPACE;
            end else if (roll < 70) begin
               cmd = random_req(FUNC_GOTO);
               // mostly on screen, sometimes clamped
               if ($urandom_range(0, 7) != 0) begin
                  cmd.goto_col = GCOL_W'($urandom_range(0, SCREEN_COLS - 1));
                  cmd.goto_row = GROW_W'($urandom_range(0, SCREEN_ROWS - 1));
               end
            end else if (roll < 90) begin
               cmd = random_req(FUNC_READ);
               if ($urandom_range(0, 7) != 0)
                  cmd.read_index = RIDX_W'($urandom_range(0, SCREEN_CELLS - 1));
            end else if (roll < 93) begin
               cmd = random_req(FUNC_CLEAR);
            end else if (roll < 97) begin
               cmd = random_req(FUNC_SCROLL);
            end else begin
               cmd = random_req(FUNC_W'($urandom_range(int'(FUNC_READ) + 1, 7)));
            end
            pending_cmds.push_back(cmd);
            made++;
         end
      end
   endtask

   // APB write: setup, then access; the register takes the value at the
   // edge where pready is seen with the access phase.
   task automatic csr_write(input logic reg_idx, input logic [ATTR_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= {24'($urandom_range(0, 16777215)), value};  // upper bits are ignored
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (reg_idx == REG_TEXT_COLOR)
         text_attr = value;
      else
         blank_attr = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // sampled on the falling edge so the driver's pops have settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || predicted_rsps.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pass on reset colors. The block holds off requests during
      // its post-reset clearing pass; the handshake takes care of that.
      pending_cmds.push_back(make_req(FUNC_PUT, CH_BACKSPACE, 0, 0, 0, 0));  // at origin
      pending_cmds.push_back(make_req(FUNC_READ, 0, 0, 0, 0, 0));           // reset cell
      pending_cmds.push_back(make_req(FUNC_PUT, 8'hff, 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_PUT, CH_BLANK, 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_PUT, "A", 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_READ, 0, 0, 0, 0, 1));
      pending_cmds.push_back(make_req(FUNC_PUT, CH_BACKSPACE, 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_PUT, CH_NEWLINE, 0, 0, 0, 0));
      // backspace from column 0 of row 1 lands on the end of row 0
      pending_cmds.push_back(make_req(FUNC_PUT, CH_BACKSPACE, 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_GOTO, 0, '1, '1, 0, 0));           // clamped
      pending_cmds.push_back(make_req(FUNC_PUT, "~", 0, 0, 0, 0));           // wraps, scrolls
      pending_cmds.push_back(make_req(FUNC_READ, 0, 0, 0, 0,
                                      RIDX_W'(SCREEN_CELLS - SCREEN_COLS - 1)));
      pending_cmds.push_back(make_req(FUNC_GOTO, 0, GCOL_W'(SCREEN_COLS - 1),
                                      GROW_W'(SCREEN_ROWS - 1), 0, 0));
      pending_cmds.push_back(make_req(FUNC_PUT, CH_NEWLINE, 0, 0, 0, 0));    // off last row
      pending_cmds.push_back(make_req(FUNC_GOTO, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_SCROLL, 0, 0, 0, 1, 0));          // row stays 0
      pending_cmds.push_back(make_req(FUNC_GOTO, 0, 3, 10, 0, 0));
      pending_cmds.push_back(make_req(FUNC_SCROLL, 0, 0, 0, 1, 0));
      pending_cmds.push_back(make_req(FUNC_SCROLL, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_READ, 0, 0, 0, 0,
                                      RIDX_W'(SCREEN_CELLS)));                // past grid
      pending_cmds.push_back(make_req(FUNC_READ, 0, 0, 0, 0, '1));
      pending_cmds.push_back(make_req(3'(FUNC_READ + 1), 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_req('1, '1, '1, '1, 1, '1));
      pending_cmds.push_back(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_req(FUNC_READ, 0, 0, 0, 0, 0));
      wait_drained();

      // color extremes, normal idling
      csr_write(REG_TEXT_COLOR, 8'h00);
      csr_write(REG_BLANK_COLOR, 8'hff);
      queue_random_cmds(405);
      wait_drained();

      // opposite extremes with both sides running flat out
      csr_write(REG_TEXT_COLOR, 8'hff);
      csr_write(REG_BLANK_COLOR, 8'h00);
      feed_calm = 1'b1;
      sink_calm = 1'b1;
      queue_random_cmds(405);
      wait_drained();
      feed_calm = 1'b0;
      sink_calm = 1'b0;

      // random colors; the drain between phases also makes the sender wait
      // for every outstanding result
      repeat (2) begin
         csr_write(REG_TEXT_COLOR, ATTR_W'($urandom_range(0, 255)));
         csr_write(REG_BLANK_COLOR, ATTR_W'($urandom_range(0, 255)));
         queue_random_cmds(405);
         wait_drained();
      end

      // let any stray result surface (longest pass is a full screen walk)
      repeat (2 * SCREEN_CELLS + 100) @(posedge clock);
      if (predicted_rsps.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog, several times above a run where every command walks the screen
   initial begin
      #200_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
